[hdl/i2cms_pkg.sv]
package i2cms_pkg;

  // Store geometry.
  localparam int BUF_DEPTH = 16;
  localparam int BUF_AW    = $clog2(BUF_DEPTH);
  localparam int CNT_W     = 5;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Control register bit masks.
  localparam logic [5:0] BIT_AA  = 6'h04;
  localparam logic [5:0] BIT_SI  = 6'h08;
  localparam logic [5:0] BIT_STO = 6'h10;
  localparam logic [5:0] BIT_STA = 6'h20;

  // Interface status codes with their own handling. Everything else
  // (no-ack codes, bus error) takes the abort path.
  localparam logic [7:0] ST_START       = 8'h08;
  localparam logic [7:0] ST_RESTART     = 8'h10;
  localparam logic [7:0] ST_ADDR_W_ACK  = 8'h18;
  localparam logic [7:0] ST_DATA_W_ACK  = 8'h28;
  localparam logic [7:0] ST_ARB_LOST    = 8'h38;
  localparam logic [7:0] ST_ADDR_R_ACK  = 8'h40;
  localparam logic [7:0] ST_DATA_R_ACK  = 8'h50;
  localparam logic [7:0] ST_DATA_R_NACK = 8'h58;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_SLAVE_ADDR = 2'd0;
  localparam logic [1:0] REG_XFER_LEN   = 2'd1;
  localparam logic [1:0] REG_REP_START  = 2'd2;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_LOAD   = 2'd1,
    KIND_READ   = 2'd2,
    KIND_BEGIN  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] status_code;
    logic [7:0] data_byte;
    logic [3:0] index;
  } item_t;

  typedef struct packed {
    logic [7:0]       slave_address_rw;
    logic [CNT_W-1:0] transfer_length;
    logic             repeat_start;
  } cfg_t;

  typedef struct packed {
    logic [5:0] ctrl_set;
    logic [5:0] ctrl_clear;
    logic       send_valid;
    logic [7:0] send_byte;
    logic       transfer_done;
    logic [7:0] read_byte;
  } result_t;

  typedef struct packed {
    logic [CNT_W-1:0] byte_count;
    logic             tx_we;
    logic             rx_we;
  } upd_t;

endpackage

[hdl/i2cms_decode.sv]
module i2cms_decode
  import i2cms_pkg::*;
(
  input  item_t            item_i,
  input  cfg_t             cfg_i,
  input  logic [CNT_W-1:0] byte_count_i,
  input  logic [7:0]       tx_rd_i,
  input  logic [7:0]       rx_rd_i,
  output result_t          result_o,
  output upd_t             upd_o
);

  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] cnt_rx;
  logic             cnt_in_buf;
  logic             idx_in_buf;
  logic             cnt_lt_len;
  logic             more_to_read;
  logic [7:0]       next_tx;

  always_comb begin
    cnt_inc      = (byte_count_i == CNT_MAX) ? byte_count_i : byte_count_i + 1'b1;
    cnt_rx       = (item_i.status_code == ST_DATA_R_ACK) ? cnt_inc : byte_count_i;
    cnt_in_buf   = 32'(byte_count_i) < BUF_DEPTH;
    idx_in_buf   = 32'(item_i.index) < BUF_DEPTH;
    cnt_lt_len   = byte_count_i < cfg_i.transfer_length;
    more_to_read = ({1'b0, cnt_rx} + 6'd1) < {1'b0, cfg_i.transfer_length};
    next_tx      = cnt_in_buf ? tx_rd_i : 8'h00;
  end

  always_comb begin
    result_o       = '0;
    upd_o          = '0;
    upd_o.byte_count = byte_count_i;

    case (item_i.kind)
      KIND_LOAD: begin
        upd_o.tx_we = idx_in_buf;
      end
      KIND_READ: begin
        result_o.read_byte = idx_in_buf ? rx_rd_i : 8'h00;
      end
      KIND_BEGIN: begin
        upd_o.byte_count  = '0;
        result_o.ctrl_set = BIT_STA;
      end
      default: begin
        case (item_i.status_code)
          ST_START: begin
            result_o.send_valid = 1'b1;
            result_o.send_byte  = cfg_i.slave_address_rw;
            result_o.ctrl_set   = BIT_AA;
            result_o.ctrl_clear = BIT_SI;
          end
          ST_RESTART: begin
            result_o.send_valid = 1'b1;
            result_o.send_byte  = cfg_i.slave_address_rw;
            result_o.ctrl_clear = BIT_STA | BIT_SI;
          end
          ST_ADDR_W_ACK: begin
            if (cnt_lt_len) begin
              result_o.send_valid = 1'b1;
              result_o.send_byte  = next_tx;
              result_o.ctrl_set   = BIT_AA;
              result_o.ctrl_clear = BIT_STA | BIT_SI;
              upd_o.byte_count    = cnt_inc;
            end
          end
          ST_DATA_W_ACK: begin
            result_o.ctrl_clear = BIT_SI;
            if (byte_count_i == cfg_i.transfer_length) begin
              result_o.ctrl_set      = cfg_i.repeat_start ? BIT_AA : (BIT_AA | BIT_STO);
              result_o.ctrl_clear    = BIT_SI | BIT_STA;
              result_o.transfer_done = 1'b1;
            end else if (cnt_lt_len) begin
              result_o.send_valid = 1'b1;
              result_o.send_byte  = next_tx;
              result_o.ctrl_clear = BIT_SI | BIT_STA;
              upd_o.byte_count    = cnt_inc;
            end
          end
          ST_ARB_LOST: begin
            result_o.ctrl_set   = BIT_STA | BIT_AA;
            result_o.ctrl_clear = BIT_SI;
          end
          ST_ADDR_R_ACK, ST_DATA_R_ACK: begin
            // A data byte with ack stores, advances and then continues as
            // the address-acknowledged case with the updated count.
            upd_o.rx_we      = (item_i.status_code == ST_DATA_R_ACK) && cnt_in_buf;
            upd_o.byte_count = cnt_rx;
            if (more_to_read) begin
              result_o.ctrl_set   = BIT_AA;
              result_o.ctrl_clear = BIT_STA | BIT_SI;
            end else begin
              result_o.ctrl_clear = BIT_STA | BIT_AA | BIT_SI;
            end
          end
          ST_DATA_R_NACK: begin
            upd_o.rx_we            = cnt_in_buf;
            upd_o.byte_count       = cnt_inc;
            result_o.ctrl_set      = BIT_STO | BIT_AA;
            result_o.ctrl_clear    = BIT_SI;
            result_o.transfer_done = 1'b1;
          end
          default: begin
            result_o.ctrl_set      = BIT_STO | BIT_AA;
            result_o.ctrl_clear    = BIT_SI;
            result_o.transfer_done = 1'b1;
          end
        endcase
      end
    endcase
  end

endmodule

[hdl/i2c_master_status_sequencer_core.sv]
// I2C master status sequencer.
// Words arrive on the s_axis channel: tuser carries the kind (status event,
// load transmit byte, read receive byte, begin transfer) and tdata carries
// the status code, the bus or transmit byte and the store index. For each
// accepted word exactly one result word leaves on m_axis with the control
// set and clear masks, the byte to send, the done flag and the read byte.
// The user must write the configuration (slave address with R/W, transfer
// length, repeat start) over the APB port only while no word is in flight;
// the block itself does not enforce this.
// An accepted word is held in the input register; the decode, the
// counter update and the store write happen on the edge that moves it into
// the output register, which shows the result. A new word is taken every
// cycle while m_axis_tready is high, so the sustained rate is one word per
// clock. The decode and the 16-entry flip-flop stores are all that lie
// between the two registers.
// Reset clears the byte counter, the configuration and both valid flags.
// The transmit and receive stores are not cleared. When m_axis_tready is
// low the output word holds, the input register fills, and s_axis_tready
// drops until the output is taken; no word is lost or repeated.
module i2c_master_status_sequencer_core
  import i2cms_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] status_code, [15:8] data_byte, [19:16] index, [23:20] zero
  input  logic [23:0] s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]  s_axis_tuser,
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [5:0] ctrl_set, [11:6] ctrl_clear, [12] send_valid, [20:13] send_byte,
  // [21] transfer_done, [29:22] read_byte, [31:30] zero
  output logic [31:0] m_axis_tdata,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t             cfg_q;
  logic             in_valid_q;
  item_t            in_item_q;
  logic             out_valid_q;
  result_t          out_q;
  logic [CNT_W-1:0] byte_count_q;

  logic [7:0] tx_store [BUF_DEPTH];
  logic [7:0] rx_store [BUF_DEPTH];

  logic    advance;
  logic    commit;
  logic    cfg_wr;
  result_t result;
  upd_t    upd;
  logic [7:0] tx_rd;
  logic [7:0] rx_rd;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_SLAVE_ADDR: cfg_q.slave_address_rw <= pwdata[7:0];
        REG_XFER_LEN:   cfg_q.transfer_length  <= pwdata[CNT_W-1:0];
        REG_REP_START:  cfg_q.repeat_start     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SLAVE_ADDR: prdata = {24'h0, cfg_q.slave_address_rw};
      REG_XFER_LEN:   prdata = {{(32-CNT_W){1'b0}}, cfg_q.transfer_length};
      REG_REP_START:  prdata = {31'h0, cfg_q.repeat_start};
      default:        prdata = '0;
    endcase
  end

  // The output register takes a new word whenever it is empty or being
  // drained; the input register refills in the same cycle.
  assign advance       = !out_valid_q || m_axis_tready;
  assign commit        = advance && in_valid_q;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q.kind        <= kind_e'(s_axis_tuser);
      in_item_q.status_code <= s_axis_tdata[7:0];
      in_item_q.data_byte   <= s_axis_tdata[15:8];
      in_item_q.index       <= s_axis_tdata[19:16];
    end
  end

  // Store reads: the transmit side follows the byte counter, the receive
  // side follows the item's index. Out-of-range cases are masked in decode.
  assign tx_rd = tx_store[BUF_AW'(byte_count_q)];
  assign rx_rd = rx_store[BUF_AW'(in_item_q.index)];

  i2cms_decode u_decode (
    .item_i       (in_item_q),
    .cfg_i        (cfg_q),
    .byte_count_i (byte_count_q),
    .tx_rd_i      (tx_rd),
    .rx_rd_i      (rx_rd),
    .result_o     (result),
    .upd_o        (upd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (commit) begin
        byte_count_q <= upd.byte_count;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_q <= result;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit && upd.tx_we) begin
      tx_store[BUF_AW'(in_item_q.index)] <= in_item_q.data_byte;
    end
    if (commit && upd.rx_we) begin
      rx_store[BUF_AW'(byte_count_q)] <= in_item_q.data_byte;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.read_byte, out_q.transfer_done, out_q.send_byte,
                          out_q.send_valid, out_q.ctrl_clear, out_q.ctrl_set};

endmodule

[hdl/i2cms_checker.sv]
module i2cms_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // A stalled result word must hold.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // No control bit is ever both set and cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[5:0] & m_axis_tdata[11:6]) == 6'h00)
    else $error("control set and clear masks overlap");

  // A byte to send is zero unless it is marked valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[12] |-> m_axis_tdata[20:13] == 8'h00)
    else $error("send byte without send valid");

  // A read answer carries no bus action.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[29:22] != 8'h00 |->
      m_axis_tdata[21:0] == 22'h0)
    else $error("read answer mixed with bus control");

  // Finishing or aborting a transfer always clears SI.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[21] |-> m_axis_tdata[9])
    else $error("transfer done without SI clear");

endmodule

bind i2c_master_status_sequencer_core i2cms_checker u_i2cms_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[tb/sv/tb_top.sv]
module tb_top;
  import i2cms_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Status codes that the block handles as a bus error. They get no named
  // constant in the package, so they are named here for the directed part.
  localparam logic [7:0] ST_BUS_ERROR   = 8'h00;
  localparam logic [7:0] ST_ADDR_W_NACK = 8'h20;
  localparam logic [7:0] ST_DATA_W_NACK = 8'h30;
  localparam logic [7:0] ST_ADDR_R_NACK = 8'h48;
  localparam logic [7:0] ST_NO_INFO     = 8'hF8;

  // The run is stopped here if it hangs. The slowest correct run is about
  // 500 words, plus the long receiver hold-off.
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_REPORTS = 10;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [7:0] status_code, [15:8] data_byte, [19:16] index, [23:20] zero
  logic [23:0] s_axis_tdata = '0;
  // [1:0] kind
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [5:0] ctrl_set, [11:6] ctrl_clear, [12] send_valid, [20:13] send_byte,
  // [21] transfer_done, [29:22] read_byte, [31:30] zero
  logic [31:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  i2c_master_status_sequencer_core i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the sequencer: configuration, byte counter and the two
  // stores. The written masks record which store entries hold a defined
  // byte, so that stimulus never reads an entry that was never written.
  cfg_t                 cfg = '0;
  logic [CNT_W-1:0]     byte_cnt = '0;
  logic [7:0]           tx_mem [BUF_DEPTH];
  logic [7:0]           rx_mem [BUF_DEPTH];
  logic [BUF_DEPTH-1:0] tx_written = '0;
  logic [BUF_DEPTH-1:0] rx_written = '0;

  // Answers predicted for accepted words, oldest first.
  result_t     answers_due [$];

  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  int unsigned words_sent = 0;
  // When set, both sides draw random waits; when clear, both run flat out.
  bit          idle_on = 1'b1;
  // A nonzero value makes the receiver hold off for that many cycles once.
  int unsigned hold_len = 0;

  logic [7:0] known_codes [8] = '{ST_START, ST_RESTART, ST_ADDR_W_ACK, ST_DATA_W_ACK,
                                  ST_ARB_LOST, ST_ADDR_R_ACK, ST_DATA_R_ACK,
                                  ST_DATA_R_NACK};

  // ---------------------------------------------------------------------
  // Prediction.
  // ---------------------------------------------------------------------

  // The counter saturates instead of wrapping.
  function automatic void bump_count();
    if (byte_cnt != CNT_MAX) begin
      byte_cnt = byte_cnt + 1'b1;
    end
  endfunction

  // The transmit byte at the counter, or zero once the counter is past the
  // end of the store.
  function automatic logic [7:0] tx_at_count();
    return (byte_cnt < BUF_DEPTH) ? tx_mem[byte_cnt[BUF_AW-1:0]] : 8'h00;
  endfunction

  // A received byte is dropped once the counter is past the end of the store.
  function automatic void capture_rx(logic [7:0] data);
    if (byte_cnt < BUF_DEPTH) begin
      rx_mem[byte_cnt[BUF_AW-1:0]] = data;
      rx_written[byte_cnt[BUF_AW-1:0]] = 1'b1;
    end
  endfunction

  // Works out the answer to one word and advances the shadow state.
  function automatic result_t sequencer_answer(item_t w);
    result_t     r;
    int unsigned len;
    r = '0;
    len = 32'(cfg.transfer_length);
    case (w.kind)
      KIND_LOAD: begin
        tx_mem[w.index] = w.data_byte;
        tx_written[w.index] = 1'b1;
      end
      KIND_READ: begin
        r.read_byte = rx_mem[w.index];
      end
      KIND_BEGIN: begin
        byte_cnt = '0;
        r.ctrl_set = BIT_STA;
      end
      default: begin
        case (w.status_code)
          ST_START: begin
            r.send_valid = 1'b1;
            r.send_byte = cfg.slave_address_rw;
            r.ctrl_set = BIT_AA;
            r.ctrl_clear = BIT_SI;
          end
          ST_RESTART: begin
            r.send_valid = 1'b1;
            r.send_byte = cfg.slave_address_rw;
            r.ctrl_clear = BIT_STA | BIT_SI;
          end
          ST_ADDR_W_ACK: begin
            // Nothing happens once the whole length has gone out.
            if (byte_cnt < len) begin
              r.send_valid = 1'b1;
              r.send_byte = tx_at_count();
              r.ctrl_set = BIT_AA;
              r.ctrl_clear = BIT_STA | BIT_SI;
              bump_count();
            end
          end
          ST_DATA_W_ACK: begin
            r.ctrl_clear = BIT_SI;
            if (byte_cnt == len) begin
              r.ctrl_set = cfg.repeat_start ? BIT_AA : (BIT_AA | BIT_STO);
              r.ctrl_clear = BIT_SI | BIT_STA;
              r.transfer_done = 1'b1;
            end else if (byte_cnt < len) begin
              r.send_valid = 1'b1;
              r.send_byte = tx_at_count();
              r.ctrl_clear = BIT_SI | BIT_STA;
              bump_count();
            end
          end
          ST_ARB_LOST: begin
            r.ctrl_set = BIT_STA | BIT_AA;
            r.ctrl_clear = BIT_SI;
          end
          ST_DATA_R_ACK, ST_ADDR_R_ACK: begin
            // A data byte is stored first, then the address case follows.
            if (w.status_code == ST_DATA_R_ACK) begin
              capture_rx(w.data_byte);
              bump_count();
            end
            if (int'(byte_cnt) + 1 < int'(len)) begin
              r.ctrl_set = BIT_AA;
              r.ctrl_clear = BIT_STA | BIT_SI;
            end else begin
              r.ctrl_clear = BIT_STA | BIT_AA | BIT_SI;
            end
          end
          ST_DATA_R_NACK: begin
            capture_rx(w.data_byte);
            bump_count();
            r.ctrl_set = BIT_STO | BIT_AA;
            r.ctrl_clear = BIT_SI;
            r.transfer_done = 1'b1;
          end
          default: begin
            // Every other code is treated as a bus error and aborts.
            r.ctrl_set = BIT_STO | BIT_AA;
            r.ctrl_clear = BIT_SI;
            r.transfer_done = 1'b1;
          end
        endcase
      end
    endcase
    return r;
  endfunction

  // Rewrites a word that would read a store entry never written since
  // reset. A read is moved to a written entry, or becomes a load; a send
  // from an unwritten transmit entry becomes a load of that entry.
  function automatic item_t keep_defined(item_t w);
    item_t       f;
    int unsigned len;
    f = w;
    len = 32'(cfg.transfer_length);
    if (f.kind == KIND_READ && !rx_written[f.index]) begin
      if (rx_written == '0) begin
        f.kind = KIND_LOAD;
      end else begin
        do f.index = 4'($urandom_range(0, BUF_DEPTH - 1));
        while (!rx_written[f.index]);
      end
    end else if (f.kind == KIND_STATUS && byte_cnt < len && byte_cnt < BUF_DEPTH &&
                 (f.status_code == ST_ADDR_W_ACK || f.status_code == ST_DATA_W_ACK) &&
                 !tx_written[byte_cnt[BUF_AW-1:0]]) begin
      f.kind = KIND_LOAD;
      f.index = byte_cnt[BUF_AW-1:0];
    end
    return f;
  endfunction

  // ---------------------------------------------------------------------
  // Checking.
  // ---------------------------------------------------------------------

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      err_count++;
      if (err_count <= MAX_REPORTS) begin
        $display("mismatch in %s: expected %0h, got %0h", name, want, got);
      end
    end
  endfunction

  // Every result word taken from the block is matched against the oldest
  // predicted answer. All signals are sampled as they were before the edge.
  always @(posedge clk) begin : check_answers
    result_t want;
    if (rst_n && m_axis_tvalid && m_axis_tready) begin
      if (answers_due.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS) begin
          $display("result word %h arrived with no word outstanding", m_axis_tdata);
        end
      end else begin
        want = answers_due.pop_front();
        compare_field("ctrl_set", 32'(want.ctrl_set), 32'(m_axis_tdata[5:0]));
        compare_field("ctrl_clear", 32'(want.ctrl_clear), 32'(m_axis_tdata[11:6]));
        compare_field("send_valid", 32'(want.send_valid), 32'(m_axis_tdata[12]));
        compare_field("send_byte", 32'(want.send_byte), 32'(m_axis_tdata[20:13]));
        compare_field("transfer_done", 32'(want.transfer_done), 32'(m_axis_tdata[21]));
        compare_field("read_byte", 32'(want.read_byte), 32'(m_axis_tdata[29:22]));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Receiver. Before each result word it draws a wait, or takes the long
  // hold-off when one is asked for, counting the cycles itself.
  // ---------------------------------------------------------------------
  initial begin : drain_results
    int unsigned stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_len != 0) begin
        stall = hold_len;
        hold_len = 0;
      end else begin
        stall = idle_on ? $urandom_range(0, 13) : 0;
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk);
      while (!m_axis_tvalid);
    end
  end

  // ---------------------------------------------------------------------
  // Sender side.
  // ---------------------------------------------------------------------

  // Offers one word, after a random gap when idle_on is set, and returns at
  // the edge where it is taken. tvalid stays high on return so that back-to-back
  // words follow without a bubble; whoever goes idle next lowers it.
  task automatic send_word(kind_e kind_v, logic [7:0] code, logic [7:0] data,
                           logic [3:0] idx);
    item_t       w;
    int unsigned gap;
    w.kind = kind_v;
    w.status_code = code;
    w.data_byte = data;
    w.index = idx;
    gap = idle_on ? $urandom_range(0, 13) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    w = keep_defined(w);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'h0, w.index, w.data_byte, w.status_code};
    s_axis_tuser <= w.kind;
    do @(posedge clk);
    while (!s_axis_tready);
    answers_due.push_back(sequencer_answer(w));
    words_sent++;
  endtask

  // Status events and begin words carry random filler in unused fields.
  task automatic send_status(logic [7:0] code);
    send_word(KIND_STATUS, code, 8'($urandom), 4'($urandom));
  endtask

  task automatic send_begin();
    send_word(KIND_BEGIN, 8'($urandom), 8'($urandom), 4'($urandom));
  endtask

  // Stops offering words and waits until every answer has come back, then
  // lets the two-stage pipeline settle for good measure.
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk);
    while (answers_due.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  // One register write followed by a read-back of the same register.
  task automatic write_reg(logic [1:0] reg_idx, logic [31:0] value);
    logic [31:0] readback;
    case (reg_idx)
      REG_SLAVE_ADDR: readback = {24'h0, value[7:0]};
      REG_XFER_LEN:   readback = {27'h0, value[CNT_W-1:0]};
      default:        readback = {31'h0, value[0]};
    endcase
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    case (reg_idx)
      REG_SLAVE_ADDR: cfg.slave_address_rw = value[7:0];
      REG_XFER_LEN:   cfg.transfer_length = value[CNT_W-1:0];
      default:        cfg.repeat_start = value[0];
    endcase
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    compare_field("register read-back", readback, prdata);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // New settings go in only once the block has nothing in flight.
  task automatic set_config(logic [7:0] addr_rw, int unsigned len, bit rep);
    wait_drain();
    write_reg(REG_SLAVE_ADDR, {24'h0, addr_rw});
    write_reg(REG_XFER_LEN, len);
    write_reg(REG_REP_START, {31'h0, rep});
  endtask

  // Now and then a step of a sequence is replaced by a random code, which
  // gives broken and aborted transfers.
  function automatic logic [7:0] may_break(logic [7:0] code);
    logic [7:0] noise;
    noise = 8'($urandom);
    return ($urandom_range(0, 15) == 0) ? noise : code;
  endfunction

  // ---------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------

  // A two-byte write ending in a stop, with the store index and data at
  // their extremes.
  task automatic test_write_transfer();
    set_config(8'hFF, 2, 1'b0);
    send_word(KIND_LOAD, 8'h00, 8'hFF, 4'h0);
    send_word(KIND_LOAD, 8'hFF, 8'h00, 4'h1);
    send_word(KIND_LOAD, 8'h00, 8'hA5, 4'hF);
    send_begin();
    send_status(ST_START);
    send_status(ST_ADDR_W_ACK);
    send_status(ST_DATA_W_ACK);
    send_status(ST_DATA_W_ACK);
  endtask

  // With repeat start the stop is left out. Shrinking the length afterwards
  // puts the counter past it: a data ack then only clears SI and an address
  // ack does nothing at all.
  task automatic test_repeat_start();
    set_config(8'h00, 2, 1'b1);
    send_begin();
    send_status(ST_RESTART);
    send_status(ST_ADDR_W_ACK);
    send_status(ST_DATA_W_ACK);
    send_status(ST_DATA_W_ACK);
    set_config(8'h00, 0, 1'b1);
    send_status(ST_DATA_W_ACK);
    send_status(ST_ADDR_W_ACK);
  endtask

  // A three-byte read: the acked bytes fall through into the address case,
  // the last one is nacked, and the stored bytes are read back.
  task automatic test_read_transfer();
    set_config(8'hA1, 3, 1'b0);
    send_begin();
    send_status(ST_START);
    send_status(ST_ADDR_R_ACK);
    send_word(KIND_STATUS, ST_DATA_R_ACK, 8'h00, 4'hF);
    send_word(KIND_STATUS, ST_DATA_R_ACK, 8'hFF, 4'h0);
    send_word(KIND_STATUS, ST_DATA_R_NACK, 8'h5A, 4'h0);
    send_word(KIND_READ, 8'h00, 8'h00, 4'h0);
    send_word(KIND_READ, 8'hFF, 8'hFF, 4'h1);
    send_word(KIND_READ, 8'h00, 8'h00, 4'h2);
  endtask

  // Arbitration loss and a selection of codes taken as a bus error.
  task automatic test_bus_errors();
    send_status(ST_ARB_LOST);
    send_status(ST_BUS_ERROR);
    send_status(ST_ADDR_W_NACK);
    send_status(ST_DATA_W_NACK);
    send_status(ST_ADDR_R_NACK);
    send_status(ST_NO_INFO);
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering words with no gaps, so the block fills and stalls its input.
  // The sender then pauses until every answer is back.
  task automatic test_backpressure();
    idle_on = 1'b0;
    hold_len = 80;
    repeat (20) begin
      send_word(KIND_STATUS, known_codes[$urandom_range(0, 7)], 8'($urandom),
                4'($urandom));
    end
    wait_drain();
    idle_on = 1'b1;
  endtask

  // One random transfer, run of received bytes, or burst of noise words.
  task automatic random_sequence();
    int unsigned len;
    int unsigned choice;
    len = 32'(cfg.transfer_length);
    choice = $urandom_range(0, 9);
    idle_on = ($urandom_range(0, 3) != 0);
    case (choice)
      0, 1, 2: begin
        repeat ($urandom_range(0, 3)) begin
          send_word(KIND_LOAD, 8'($urandom), 8'($urandom), 4'($urandom));
        end
        send_begin();
        send_status(may_break($urandom_range(0, 1) ? ST_START : ST_RESTART));
        send_status(may_break(ST_ADDR_W_ACK));
        // One more data ack than needed now and then, past the done point.
        repeat ((len > 1 ? len - 1 : 0) + 1 + $urandom_range(0, 1)) begin
          send_status(may_break(ST_DATA_W_ACK));
        end
      end
      3, 4, 5: begin
        send_begin();
        send_status(may_break(ST_START));
        send_status(may_break(ST_ADDR_R_ACK));
        repeat (len > 1 ? len - 1 : 0) send_status(may_break(ST_DATA_R_ACK));
        send_status(may_break(ST_DATA_R_NACK));
        repeat ($urandom_range(1, 3)) begin
          send_word(KIND_READ, 8'($urandom), 8'($urandom), 4'($urandom));
        end
      end
      6: begin
        // Can run long enough to pass the store depth and reach saturation.
        send_begin();
        send_status(ST_ADDR_R_ACK);
        repeat ($urandom_range(14, 40)) send_status(ST_DATA_R_ACK);
      end
      7: begin
        send_status(ST_ARB_LOST);
        send_begin();
        send_status(ST_RESTART);
      end
      default: begin
        repeat ($urandom_range(1, 4)) begin
          send_word(kind_e'($urandom_range(0, 3)),
                    $urandom_range(0, 1) ? known_codes[$urandom_range(0, 7)] : 8'($urandom),
                    8'($urandom), 4'($urandom));
        end
      end
    endcase
  endtask

  // Several settings in turn, the extremes first, about fifty words each.
  task automatic test_random();
    int unsigned target;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       set_config(8'h00, 0, 1'b0);
        1:       set_config(8'hFF, 16, 1'b1);
        2:       set_config(8'($urandom), 1, 1'b0);
        default: set_config(8'($urandom), $urandom_range(0, 16), 1'($urandom_range(0, 1)));
      endcase
      target = words_sent + 50;
      while (words_sent < target) random_sequence();
    end
    idle_on = 1'b1;
  endtask

  // Reset is held first, then the tests run one after another.
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_write_transfer();
    test_repeat_start();
    test_read_transfer();
    test_bus_errors();
    test_backpressure();
    test_random();
    wait_drain();
    if (err_count == 0 && answers_due.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

[i2c_master_status_sequencer_core.f]
hdl/i2cms_pkg.sv
hdl/i2cms_decode.sv
hdl/i2c_master_status_sequencer_core.sv
hdl/i2cms_checker.sv
tb/sv/tb_top.sv
